// ----- rtl/core/smx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and constants of the stack machine executor.
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int MEM_WORDS   = 1024;
  localparam int ADDR_W      = $clog2(MEM_WORDS);
  localparam int DATA_W      = 32;
  localparam int EXT_W       = DATA_W + 2;
  localparam int CODE_W      = 16;
  localparam int CNT_W       = 64;
  localparam int OPC_W       = 4;
  localparam int ALU_W       = 4;
  localparam int FAULT_W     = 3;
  localparam int ARG_NUM     = 8;
  localparam int ARG_IDX_W   = $clog2(ARG_NUM);
  localparam int CFG_IDX_W   = 4;
  localparam int IP_STEP     = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [OPC_W-1:0] OP_LIT = 4'd0;
  localparam logic [OPC_W-1:0] OP_LOD = 4'd1;
  localparam logic [OPC_W-1:0] OP_STO = 4'd2;
  localparam logic [OPC_W-1:0] OP_INT = 4'd3;
  localparam logic [OPC_W-1:0] OP_JMP = 4'd4;
  localparam logic [OPC_W-1:0] OP_JZ  = 4'd5;
  localparam logic [OPC_W-1:0] OP_JNZ = 4'd6;
  localparam logic [OPC_W-1:0] OP_CAL = 4'd7;
  localparam logic [OPC_W-1:0] OP_OPR = 4'd8;
  localparam logic [OPC_W-1:0] OP_EXT = 4'd9;

  localparam logic [ALU_W-1:0] SUB_ADD  = 4'd0;
  localparam logic [ALU_W-1:0] SUB_SUB  = 4'd1;
  localparam logic [ALU_W-1:0] SUB_MUL  = 4'd2;
  localparam logic [ALU_W-1:0] SUB_DIV  = 4'd3;
  localparam logic [ALU_W-1:0] SUB_MOD  = 4'd4;
  localparam logic [ALU_W-1:0] SUB_LT   = 4'd5;
  localparam logic [ALU_W-1:0] SUB_GT   = 4'd6;
  localparam logic [ALU_W-1:0] SUB_EQ   = 4'd7;
  localparam logic [ALU_W-1:0] SUB_NE   = 4'd8;
  localparam logic [ALU_W-1:0] SUB_LE   = 4'd9;
  localparam logic [ALU_W-1:0] SUB_GE   = 4'd10;
  localparam logic [ALU_W-1:0] SUB_HALT = 4'd11;
  localparam logic [ALU_W-1:0] SUB_RET  = 4'd12;

  localparam logic [DATA_W-1:0] EXT_DOT = 32'd0;
  localparam logic [DATA_W-1:0] EXT_AST = 32'd1;
  localparam logic [DATA_W-1:0] EXT_ARG = 32'd2;

  localparam logic [FAULT_W-1:0] FLT_NONE   = 3'd0;
  localparam logic [FAULT_W-1:0] FLT_DIV0   = 3'd1;
  localparam logic [FAULT_W-1:0] FLT_ADDR   = 3'd2;
  localparam logic [FAULT_W-1:0] FLT_AST    = 3'd3;
  localparam logic [FAULT_W-1:0] FLT_OPCODE = 3'd4;

  typedef enum logic [3:0] {
    CL_LIT, CL_LOD, CL_STO, CL_INT, CL_JMP, CL_JZ, CL_JNZ, CL_CAL,
    CL_BIN, CL_HALT, CL_RET, CL_NOP, CL_DOT, CL_AST, CL_ARG, CL_BAD
  } cls_t;

  typedef struct packed {
    cls_t              cls;
    logic [ALU_W-1:0]  alu;
    logic [DATA_W-1:0] operand;
  } item_t;

  typedef struct packed {
    logic [CODE_W-1:0]  next_ip;
    logic [DATA_W-1:0]  top_value;
    logic               print_valid;
    logic               halted;
    logic [FAULT_W-1:0] fault;
    logic [ADDR_W-1:0]  stack_ptr;
    logic [ADDR_W-1:0]  return_ptr;
    logic [ADDR_W-1:0]  frame_ptr;
    logic [CNT_W-1:0]   instr_count;
  } res_t;

  typedef enum logic [9:0] {
    ST_CLR  = 10'b0000000001,
    ST_IDLE = 10'b0000000010,
    ST_DEC  = 10'b0000000100,
    ST_RDB  = 10'b0000001000,
    ST_EXE  = 10'b0000010000,
    ST_DIV  = 10'b0000100000,
    ST_DWR  = 10'b0001000000,
    ST_WR2  = 10'b0010000000,
    ST_TOP  = 10'b0100000000,
    ST_OUT  = 10'b1000000000
  } st_t;

endpackage

// ----- rtl/core/smx_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module smx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/smx_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_front
// Accepts instructions, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module smx_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       hold,
  input  logic                       push,
  output logic                       full,
  input  logic [smx_pkg::OPC_W-1:0]  opcode,
  input  logic [smx_pkg::DATA_W-1:0] operand,
  output logic                       q_valid,
  output smx_pkg::item_t             q_item,
  input  logic                       q_pop
);

  smx_pkg::item_t              slot [smx_pkg::QUEUE_DEPTH];
  logic [smx_pkg::QPTR_W-1:0]  wr_ptr;
  logic [smx_pkg::QPTR_W-1:0]  rd_ptr;
  logic [smx_pkg::QCNT_W-1:0]  count;
  smx_pkg::item_t              item_in;
  logic                        do_push;
  logic                        do_pop;
  logic                        small_op;

  assign full    = (count == smx_pkg::QCNT_W'(smx_pkg::QUEUE_DEPTH)) || hold;
  assign do_push = push && !full;
  assign q_valid = (count != '0);
  assign do_pop  = q_pop && q_valid;
  assign q_item  = slot[rd_ptr];
  assign small_op = (operand[smx_pkg::DATA_W-1:smx_pkg::ALU_W] == '0);

  always_comb begin
    item_in.operand = operand;
    item_in.alu     = operand[smx_pkg::ALU_W-1:0];
    item_in.cls     = smx_pkg::CL_BAD;
    case (opcode)
      smx_pkg::OP_LIT: item_in.cls = smx_pkg::CL_LIT;
      smx_pkg::OP_LOD: item_in.cls = smx_pkg::CL_LOD;
      smx_pkg::OP_STO: item_in.cls = smx_pkg::CL_STO;
      smx_pkg::OP_INT: item_in.cls = smx_pkg::CL_INT;
      smx_pkg::OP_JMP: item_in.cls = smx_pkg::CL_JMP;
      smx_pkg::OP_JZ:  item_in.cls = smx_pkg::CL_JZ;
      smx_pkg::OP_JNZ: item_in.cls = smx_pkg::CL_JNZ;
      smx_pkg::OP_CAL: item_in.cls = smx_pkg::CL_CAL;
      smx_pkg::OP_OPR: begin
        if (small_op && operand[smx_pkg::ALU_W-1:0] <= smx_pkg::SUB_GE) begin
          item_in.cls = smx_pkg::CL_BIN;
        end else if (small_op && operand[smx_pkg::ALU_W-1:0] == smx_pkg::SUB_HALT) begin
          item_in.cls = smx_pkg::CL_HALT;
        end else if (small_op && operand[smx_pkg::ALU_W-1:0] == smx_pkg::SUB_RET) begin
          item_in.cls = smx_pkg::CL_RET;
        end else begin
          item_in.cls = smx_pkg::CL_NOP;
        end
      end
      smx_pkg::OP_EXT: begin
        if (operand == smx_pkg::EXT_DOT) begin
          item_in.cls = smx_pkg::CL_DOT;
        end else if (operand == smx_pkg::EXT_AST) begin
          item_in.cls = smx_pkg::CL_AST;
        end else if (operand == smx_pkg::EXT_ARG) begin
          item_in.cls = smx_pkg::CL_ARG;
        end else begin
          item_in.cls = smx_pkg::CL_NOP;
        end
      end
      default: item_in.cls = smx_pkg::CL_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/core/smx_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_back
// Executes queued instructions against the data memory and machine registers.
// ----------------------------------------------------------------------------
module smx_back (
  input  logic                          clk,
  input  logic                          rst,
  output logic                          clearing,
  input  logic                          q_valid,
  input  smx_pkg::item_t                q_item,
  output logic                          q_pop,
  input  logic                          cfg_valid,
  input  logic [smx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smx_pkg::DATA_W-1:0]    cfg_data,
  output logic                          res_valid,
  output smx_pkg::res_t                 res,
  input  logic                          res_pop
);

  localparam int AW = smx_pkg::ADDR_W;
  localparam int DW = smx_pkg::DATA_W;
  localparam int XW = smx_pkg::EXT_W;

  smx_pkg::st_t               state;
  smx_pkg::item_t             it;
  logic [AW-1:0]              clr_cnt;
  logic [smx_pkg::CODE_W-1:0] ip;
  logic [AW-1:0]              sp;
  logic [AW-1:0]              rp;
  logic [AW-1:0]              fp;
  logic [smx_pkg::CNT_W-1:0]  cnt;
  logic                       stopped;
  logic [smx_pkg::FAULT_W-1:0] cause;
  logic                       printed;
  logic [DW-1:0]              ra;
  logic [DW-1:0]              arg_reg [smx_pkg::ARG_NUM];

  logic                       xneg;
  logic                       yneg;
  logic [DW-1:0]              dq;
  logic [DW-1:0]              ym;
  logic [DW-1:0]              rem;
  logic [smx_pkg::DIV_CNT_W-1:0] div_cnt;
  logic [DW:0]                rem_sh;
  logic                       rem_ge;

  logic                       we;
  logic [AW-1:0]              waddr;
  logic [DW-1:0]              wdata;
  logic                       re;
  logic [AW-1:0]              raddr;
  logic [DW-1:0]              rdata;

  logic signed [XW-1:0]       fa_x;
  logic signed [XW-1:0]       ra_x;
  logic                       fa_ok;
  logic                       ra_ok;
  logic [AW-1:0]              fa;
  logic [AW-1:0]              sp_m1;
  logic [AW-1:0]              sp_m2;
  logic [smx_pkg::CODE_W-1:0] nxt;
  logic [smx_pkg::CODE_W-1:0] jtgt;
  logic [smx_pkg::FAULT_W-1:0] dec_flt;
  logic signed [DW-1:0]       xs;
  logic signed [DW-1:0]       ys;
  logic [DW-1:0]              alu_res;
  logic                       is_div;
  logic [DW-1:0]              quo;
  logic [DW-1:0]              rmd;
  logic [DW-1:0]              div_res;
  logic [DW-1:0]              arg_val;
  logic                       out_free;

  smx_ram #(
    .WIDTH(DW),
    .DEPTH(smx_pkg::MEM_WORDS)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign clearing = (state == smx_pkg::ST_CLR);
  assign q_pop    = (state == smx_pkg::ST_IDLE) && q_valid;
  assign out_free = !res_valid || res_pop;

  assign fa_x  = $signed({{(XW-AW){1'b0}}, fp}) - $signed({{2{it.operand[DW-1]}}, it.operand});
  assign ra_x  = $signed({{(XW-AW){1'b0}}, rp}) - $signed({{2{it.operand[DW-1]}}, it.operand});
  assign fa_ok = (fa_x[XW-1:AW] == '0);
  assign ra_ok = (ra_x[XW-1:AW] == '0);
  assign fa    = fa_x[AW-1:0];
  assign sp_m1 = sp - 1'b1;
  assign sp_m2 = sp - AW'(2);
  assign nxt   = ip + smx_pkg::CODE_W'(smx_pkg::IP_STEP);
  assign jtgt  = ip + it.operand[smx_pkg::CODE_W-1:0];

  always_comb begin
    dec_flt = smx_pkg::FLT_NONE;
    case (it.cls)
      smx_pkg::CL_LIT: if (sp == '1) dec_flt = smx_pkg::FLT_ADDR;
      smx_pkg::CL_LOD: if (sp == '1 || !fa_ok) dec_flt = smx_pkg::FLT_ADDR;
      smx_pkg::CL_STO: if (sp == '0 || !fa_ok) dec_flt = smx_pkg::FLT_ADDR;
      smx_pkg::CL_INT: if (!ra_ok) dec_flt = smx_pkg::FLT_ADDR;
      smx_pkg::CL_JZ, smx_pkg::CL_JNZ, smx_pkg::CL_DOT, smx_pkg::CL_ARG: begin
        if (sp == '0) dec_flt = smx_pkg::FLT_ADDR;
      end
      smx_pkg::CL_CAL: if (rp < AW'(2)) dec_flt = smx_pkg::FLT_ADDR;
      smx_pkg::CL_BIN: if (sp < AW'(2)) dec_flt = smx_pkg::FLT_ADDR;
      smx_pkg::CL_RET: if (fp >= AW'(smx_pkg::MEM_WORDS - 2)) dec_flt = smx_pkg::FLT_ADDR;
      smx_pkg::CL_BAD: dec_flt = smx_pkg::FLT_OPCODE;
      default: dec_flt = smx_pkg::FLT_NONE;
    endcase
  end

  assign xs     = $signed(rdata);
  assign ys     = $signed(ra);
  assign is_div = (it.alu == smx_pkg::SUB_DIV) || (it.alu == smx_pkg::SUB_MOD);

  always_comb begin
    alu_res = '0;
    case (it.alu)
      smx_pkg::SUB_ADD: alu_res = xs + ys;
      smx_pkg::SUB_SUB: alu_res = xs - ys;
      smx_pkg::SUB_MUL: alu_res = DW'(xs * ys);
      smx_pkg::SUB_LT:  alu_res = {{(DW-1){1'b0}}, xs < ys};
      smx_pkg::SUB_GT:  alu_res = {{(DW-1){1'b0}}, xs > ys};
      smx_pkg::SUB_EQ:  alu_res = {{(DW-1){1'b0}}, xs == ys};
      smx_pkg::SUB_NE:  alu_res = {{(DW-1){1'b0}}, xs != ys};
      smx_pkg::SUB_LE:  alu_res = {{(DW-1){1'b0}}, xs <= ys};
      smx_pkg::SUB_GE:  alu_res = {{(DW-1){1'b0}}, xs >= ys};
      default:          alu_res = '0;
    endcase
  end

  assign rem_sh  = {rem, dq[DW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, ym});
  assign quo     = (xneg ^ yneg) ? (~dq + 1'b1) : dq;
  assign rmd     = xneg ? (~rem + 1'b1) : rem;
  assign div_res = (it.alu == smx_pkg::SUB_DIV) ? quo : rmd;
  assign arg_val = (ra[DW-1:smx_pkg::ARG_IDX_W] == '0) ? arg_reg[ra[smx_pkg::ARG_IDX_W-1:0]] : '0;

  always_comb begin
    we    = 1'b0;
    waddr = sp;
    wdata = '0;
    re    = 1'b0;
    raddr = sp_m1;
    case (state)
      smx_pkg::ST_CLR: begin
        we    = 1'b1;
        waddr = clr_cnt;
      end
      smx_pkg::ST_DEC: begin
        re = 1'b1;
        if (it.cls == smx_pkg::CL_LOD) begin
          raddr = fa;
        end else if (it.cls == smx_pkg::CL_RET) begin
          raddr = fp + 1'b1;
        end
      end
      smx_pkg::ST_RDB: begin
        re    = 1'b1;
        raddr = (it.cls == smx_pkg::CL_RET) ? fp + AW'(2) : sp_m2;
      end
      smx_pkg::ST_EXE: begin
        case (it.cls)
          smx_pkg::CL_LIT: begin
            we    = 1'b1;
            wdata = it.operand;
          end
          smx_pkg::CL_LOD: begin
            we    = 1'b1;
            wdata = ra;
          end
          smx_pkg::CL_STO: begin
            we    = 1'b1;
            waddr = fa;
            wdata = ra;
          end
          smx_pkg::CL_CAL: begin
            we    = 1'b1;
            waddr = rp;
            wdata = {{(DW-AW){1'b0}}, fp};
          end
          smx_pkg::CL_BIN: begin
            we    = !is_div;
            waddr = sp_m2;
            wdata = alu_res;
          end
          smx_pkg::CL_ARG: begin
            we    = 1'b1;
            waddr = sp_m1;
            wdata = arg_val;
          end
          default: we = 1'b0;
        endcase
      end
      smx_pkg::ST_DWR: begin
        we    = 1'b1;
        waddr = sp_m2;
        wdata = div_res;
      end
      smx_pkg::ST_WR2: begin
        we    = 1'b1;
        waddr = rp - 1'b1;
        wdata = {{(DW-smx_pkg::CODE_W){1'b0}}, nxt};
      end
      smx_pkg::ST_TOP: re = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == smx_pkg::ST_IDLE && q_valid) begin
      it <= q_item;
    end
    if (state == smx_pkg::ST_RDB) begin
      ra <= rdata;
    end
    if (state == smx_pkg::ST_EXE) begin
      xneg <= rdata[DW-1];
      yneg <= ra[DW-1];
      dq   <= rdata[DW-1] ? (~rdata + 1'b1) : rdata;
      ym   <= ra[DW-1] ? (~ra + 1'b1) : ra;
      rem  <= '0;
    end else if (state == smx_pkg::ST_DIV) begin
      dq  <= {dq[DW-2:0], rem_ge};
      rem <= rem_ge ? DW'(rem_sh - {1'b0, ym}) : rem_sh[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= smx_pkg::ST_CLR;
      clr_cnt   <= '0;
      ip        <= '0;
      sp        <= '0;
      rp        <= '1;
      fp        <= '1;
      cnt       <= '0;
      stopped   <= 1'b0;
      cause     <= smx_pkg::FLT_NONE;
      printed   <= 1'b0;
      div_cnt   <= '0;
      res_valid <= 1'b0;
      for (int i = 0; i < smx_pkg::ARG_NUM; i++) begin
        arg_reg[i] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_index < smx_pkg::CFG_IDX_W'(smx_pkg::ARG_NUM)) begin
        arg_reg[cfg_index[smx_pkg::ARG_IDX_W-1:0]] <= cfg_data;
      end
      if (res_pop && res_valid && state != smx_pkg::ST_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        smx_pkg::ST_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= smx_pkg::ST_IDLE;
          end
        end
        smx_pkg::ST_IDLE: begin
          if (q_valid) begin
            state <= smx_pkg::ST_DEC;
          end
        end
        smx_pkg::ST_DEC: begin
          if (stopped) begin
            state <= smx_pkg::ST_TOP;
          end else if (dec_flt != smx_pkg::FLT_NONE) begin
            stopped <= 1'b1;
            cause   <= dec_flt;
            state   <= smx_pkg::ST_TOP;
          end else begin
            state <= smx_pkg::ST_RDB;
          end
        end
        smx_pkg::ST_RDB: state <= smx_pkg::ST_EXE;
        smx_pkg::ST_EXE: begin
          state <= (it.cls == smx_pkg::CL_CAL) ? smx_pkg::ST_WR2 :
                   (it.cls == smx_pkg::CL_BIN && is_div && ra != '0) ? smx_pkg::ST_DIV :
                   smx_pkg::ST_TOP;
          case (it.cls)
            smx_pkg::CL_LIT, smx_pkg::CL_LOD: begin
              sp  <= sp + 1'b1;
              ip  <= nxt;
              cnt <= cnt + 1'b1;
            end
            smx_pkg::CL_STO: begin
              sp  <= sp_m1;
              ip  <= nxt;
              cnt <= cnt + 1'b1;
            end
            smx_pkg::CL_INT: begin
              rp  <= ra_x[AW-1:0];
              ip  <= nxt;
              cnt <= cnt + 1'b1;
            end
            smx_pkg::CL_JMP: begin
              ip  <= jtgt;
              cnt <= cnt + 1'b1;
            end
            smx_pkg::CL_JZ, smx_pkg::CL_JNZ: begin
              sp  <= sp_m1;
              ip  <= ((ra == '0) == (it.cls == smx_pkg::CL_JZ)) ? jtgt : nxt;
              cnt <= cnt + 1'b1;
            end
            smx_pkg::CL_BIN: begin
              if (is_div && ra == '0) begin
                stopped <= 1'b1;
                cause   <= smx_pkg::FLT_DIV0;
              end else if (is_div) begin
                div_cnt <= '0;
              end else begin
                sp  <= sp_m1;
                ip  <= nxt;
                cnt <= cnt + 1'b1;
              end
            end
            smx_pkg::CL_HALT: begin
              ip      <= nxt;
              cnt     <= cnt + 1'b1;
              stopped <= 1'b1;
              cause   <= smx_pkg::FLT_NONE;
            end
            smx_pkg::CL_RET: begin
              if (rdata[DW-1:AW] != '0) begin
                stopped <= 1'b1;
                cause   <= smx_pkg::FLT_ADDR;
              end else begin
                ip  <= ra[smx_pkg::CODE_W-1:0];
                rp  <= fp + AW'(2);
                fp  <= rdata[AW-1:0];
                cnt <= cnt + 1'b1;
              end
            end
            smx_pkg::CL_DOT: begin
              printed <= 1'b1;
              ip      <= nxt;
              cnt     <= cnt + 1'b1;
            end
            smx_pkg::CL_AST: begin
              ip      <= nxt;
              stopped <= 1'b1;
              cause   <= smx_pkg::FLT_AST;
            end
            smx_pkg::CL_ARG, smx_pkg::CL_NOP: begin
              ip  <= nxt;
              cnt <= cnt + 1'b1;
            end
            default: ip <= ip;
          endcase
        end
        smx_pkg::ST_DIV: begin
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == '1) begin
            state <= smx_pkg::ST_DWR;
          end
        end
        smx_pkg::ST_DWR: begin
          sp    <= sp_m1;
          ip    <= nxt;
          cnt   <= cnt + 1'b1;
          state <= smx_pkg::ST_TOP;
        end
        smx_pkg::ST_WR2: begin
          ip    <= it.operand[smx_pkg::CODE_W-1:0];
          rp    <= rp - AW'(2);
          fp    <= rp - AW'(2);
          cnt   <= cnt + 1'b1;
          state <= smx_pkg::ST_TOP;
        end
        smx_pkg::ST_TOP: state <= smx_pkg::ST_OUT;
        smx_pkg::ST_OUT: begin
          if (out_free) begin
            res_valid           <= 1'b1;
            res.next_ip         <= ip;
            res.top_value       <= (sp == '0) ? '0 : rdata;
            res.print_valid     <= printed;
            res.halted          <= stopped;
            res.fault           <= cause;
            res.stack_ptr       <= sp;
            res.return_ptr      <= rp;
            res.frame_ptr       <= fp;
            res.instr_count     <= cnt;
            printed             <= 1'b0;
            state               <= smx_pkg::ST_IDLE;
          end
        end
        default: state <= smx_pkg::ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/stack_machine_executor_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_executor_top
// Stack machine that carries out one instruction per item.
// ----------------------------------------------------------------------------
// After reset the block clears its 1024-word data memory, one word a cycle,
// and holds full high while it clears. An instruction then runs through
// decode, operand read, execute, top-of-stack read and output; a call adds
// a second write, and divide or modulo a one-bit-a-cycle divider and a
// result write. The single read port of the data memory serves two operand
// reads and the top-of-stack read in turn. A two-item queue in front and a
// result register behind let either side stall without holding up the other.
module stack_machine_executor_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [smx_pkg::OPC_W-1:0]     opcode,
  input  logic signed [smx_pkg::DATA_W-1:0] operand,
  output logic                          empty,
  input  logic                          pop,
  output logic [smx_pkg::CODE_W-1:0]    next_ip,
  output logic signed [smx_pkg::DATA_W-1:0] top_value,
  output logic                          print_valid,
  output logic                          halted,
  output logic [smx_pkg::FAULT_W-1:0]   fault,
  output logic [smx_pkg::ADDR_W-1:0]    stack_ptr,
  output logic [smx_pkg::ADDR_W-1:0]    return_ptr,
  output logic [smx_pkg::ADDR_W-1:0]    frame_ptr,
  output logic [smx_pkg::CNT_W-1:0]     instr_count,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [smx_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [smx_pkg::DATA_W-1:0]    cfg_data
);

  logic           clearing;
  logic           q_valid;
  logic           q_pop;
  smx_pkg::item_t q_item;
  logic           res_valid;
  smx_pkg::res_t  res;

  assign cfg_ready = 1'b1;

  smx_front u_front (
    .clk    (clk),
    .rst    (rst),
    .hold   (clearing),
    .push   (push),
    .full   (full),
    .opcode (opcode),
    .operand(operand),
    .q_valid(q_valid),
    .q_item (q_item),
    .q_pop  (q_pop)
  );

  smx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .res_valid(res_valid),
    .res      (res),
    .res_pop  (pop)
  );

  assign empty       = !res_valid;
  assign next_ip     = res.next_ip;
  assign top_value   = res.top_value;
  assign print_valid = res.print_valid;
  assign halted      = res.halted;
  assign fault       = res.fault;
  assign stack_ptr   = res.stack_ptr;
  assign return_ptr  = res.return_ptr;
  assign frame_ptr   = res.frame_ptr;
  assign instr_count = res.instr_count;

endmodule

// ----- rtl/core/smx_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_checker
// Port-level checks on the stack machine executor.
// ----------------------------------------------------------------------------
module smx_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [smx_pkg::CODE_W-1:0]    next_ip,
  input logic                          print_valid,
  input logic                          halted,
  input logic [smx_pkg::FAULT_W-1:0]   fault
);

  a_reset_clear: assert property (@(posedge clk) rst |=> full && empty)
    else $error("queue state wrong after reset");

  a_print_live: assert property (@(posedge clk) disable iff (rst)
    (!empty && print_valid) |-> !halted)
    else $error("print reported on a halted machine");

  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    (!empty && fault != smx_pkg::FLT_NONE) |-> halted)
    else $error("fault reported without halt");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(next_ip)))
    else $error("waiting item changed");

endmodule

bind stack_machine_executor_top smx_checker u_smx_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .next_ip    (next_ip),
  .print_valid(print_valid),
  .halted     (halted),
  .fault      (fault)
);
